>>> rtl/tem_pkg.sv
package tem_pkg;

  localparam int unsigned COORD_W  = 20;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned LSQ_W    = PROD_W - 1;
  localparam int unsigned CROSS_W  = PROD_W + 1;
  localparam int unsigned LEN_FRAC = 20;
  localparam int unsigned RAD_W    = 62;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned DIST_SH  = 11;
  localparam int unsigned NUM_W    = CROSS_W + DIST_SH;
  localparam int unsigned DEN_W    = ROOT_W + 1;
  localparam int unsigned QUO_W    = 22;
  localparam int unsigned OUT_W    = 22;
  localparam int unsigned DVAL_W   = QUO_W + 1;
  localparam int unsigned SKIP_W   = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned EDGES    = 3;
  localparam int unsigned ANCHOR_COUNT = 4;

  localparam int unsigned SQ_STEPS = ROOT_W;
  localparam int unsigned DV_STEPS = QUO_W;
  // front end 3, sqrt init 1, sqrt steps, divider setup 2, divider steps, tail 3
  localparam int unsigned LATENCY  = 3 + 1 + SQ_STEPS + 2 + DV_STEPS + 3;

  localparam logic signed [DVAL_W-1:0] OUT_MAX = DVAL_W'(2097151);
  localparam logic signed [DVAL_W-1:0] OUT_MIN = -DVAL_W'(2097152);

endpackage

>>> rtl/triangle_edge_margin.sv
// Channel   | Ports                                              | Dir | Handshake
// command   | start, skipped_anchor_i, point_x_i, point_y_i      | in  | start && !busy
// result    | done_o, edge_margin_o                              | out | done_o strobe
// config    | cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o  | in  | valid && ready
//
// One word is taken every cycle; each result passes the front end, the 31-stage
// square root, the 22-stage divider and the tail before done_o marks it.
// busy and cfg_ready_o stay at their idle values: nothing inside stalls.
// rst_ni clears the anchors to zero and drops every word in flight.
// The receiver cannot stall; done_o lasts exactly one cycle per word.
module triangle_edge_margin import tem_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [SKIP_W-1:0]         skipped_anchor_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  output logic                      done_o,
  output logic signed [OUT_W-1:0]   edge_margin_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i
);

  typedef struct packed {
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [CROSS_W-1:0] mag;
    logic               neg;
    logic               zero;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
  } pre_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             neg;
    logic             zero;
  } dv_t;

  // One radix-4 digit of the integer square root.
  function automatic sq_t sq_step(sq_t s);
    sq_t r;
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    r     = s;
    acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = REM_W'(acc - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One bit of restoring division.
  function automatic dv_t dv_step(dv_t s);
    dv_t r;
    logic [DEN_W:0] acc;
    r    = s;
    acc  = {s.rem, s.lo[QUO_W-1]};
    r.lo = {s.lo[QUO_W-2:0], 1'b0};
    if (acc >= {1'b0, s.den}) begin
      r.rem = DEN_W'(acc - {1'b0, s.den});
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = acc[DEN_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0] anc_x_q [ANCHOR_COUNT];
  logic signed [COORD_W-1:0] anc_y_q [ANCHOR_COUNT];

  logic                      accept;
  logic [LATENCY-1:0]        vld_q;

  logic signed [COORD_W-1:0] tx [EDGES];
  logic signed [COORD_W-1:0] ty [EDGES];

  // stage 1: edge vectors and point offsets
  logic signed [DIFF_W-1:0]  ex_q [EDGES];
  logic signed [DIFF_W-1:0]  ey_q [EDGES];
  logic signed [DIFF_W-1:0]  dx_q [EDGES];
  logic signed [DIFF_W-1:0]  dy_q [EDGES];
  // stage 2: products
  logic signed [PROD_W-1:0]  pxx_q [EDGES];
  logic signed [PROD_W-1:0]  pyy_q [EDGES];
  logic signed [PROD_W-1:0]  pc1_q [EDGES];
  logic signed [PROD_W-1:0]  pc2_q [EDGES];
  logic signed [PROD_W-1:0]  ar1_q;
  logic signed [PROD_W-1:0]  ar2_q;
  logic                      z1_q [EDGES];
  // stage 3: squared length, cross product, winding
  logic [LSQ_W-1:0]          lsq_q [EDGES];
  logic signed [CROSS_W-1:0] cr_q  [EDGES];
  logic                      z2_q  [EDGES];
  logic                      aneg_q;

  sq_t  sq_q  [SQ_STEPS+1][EDGES];
  pre_t pre_q [EDGES];
  dv_t  dv_q  [DV_STEPS+1][EDGES];

  logic signed [DVAL_W-1:0]  dval_q [EDGES];
  logic                      dok_q  [EDGES];
  logic signed [DVAL_W-1:0]  best_q;
  logic signed [DVAL_W-1:0]  best_d;
  logic                      have;
  logic signed [OUT_W-1:0]   edge_margin_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Anchor registers; indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < ANCHOR_COUNT; a++) begin
        anc_x_q[a] <= '0;
        anc_y_q[a] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      if (cfg_index_i[0]) begin
        anc_y_q[cfg_index_i[2:1]] <= cfg_data_i;
      end else begin
        anc_x_q[cfg_index_i[2:1]] <= cfg_data_i;
      end
    end
  end

  // Pick the three remaining anchors in ascending order; skip above three
  // behaves like skip three.
  always_comb begin
    tx[0] = (skipped_anchor_i == SKIP_W'(0)) ? anc_x_q[1] : anc_x_q[0];
    ty[0] = (skipped_anchor_i == SKIP_W'(0)) ? anc_y_q[1] : anc_y_q[0];
    tx[1] = (skipped_anchor_i <= SKIP_W'(1)) ? anc_x_q[2] : anc_x_q[1];
    ty[1] = (skipped_anchor_i <= SKIP_W'(1)) ? anc_y_q[2] : anc_y_q[1];
    tx[2] = (skipped_anchor_i <= SKIP_W'(2)) ? anc_x_q[3] : anc_x_q[2];
    ty[2] = (skipped_anchor_i <= SKIP_W'(2)) ? anc_y_q[3] : anc_y_q[2];
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // Pick the smallest distance among edges of nonzero length.
  always_comb begin
    best_d = '0;
    have   = 1'b0;
    for (int e = 0; e < EDGES; e++) begin
      if (dok_q[e] && (!have || (dval_q[e] < best_d))) begin
        best_d = dval_q[e];
        have   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < EDGES; e++) begin
      // edge e runs from vertex e to vertex e+1 mod 3
      ex_q[e] <= {tx[(e+1)%EDGES][COORD_W-1], tx[(e+1)%EDGES]} - {tx[e][COORD_W-1], tx[e]};
      ey_q[e] <= {ty[(e+1)%EDGES][COORD_W-1], ty[(e+1)%EDGES]} - {ty[e][COORD_W-1], ty[e]};
      dx_q[e] <= {point_x_i[COORD_W-1], point_x_i} - {tx[e][COORD_W-1], tx[e]};
      dy_q[e] <= {point_y_i[COORD_W-1], point_y_i} - {ty[e][COORD_W-1], ty[e]};

      pxx_q[e] <= ex_q[e] * ex_q[e];
      pyy_q[e] <= ey_q[e] * ey_q[e];
      pc1_q[e] <= ex_q[e] * dy_q[e];
      pc2_q[e] <= ey_q[e] * dx_q[e];
      z1_q[e]  <= (ex_q[e] == '0) && (ey_q[e] == '0);

      lsq_q[e] <= LSQ_W'(pxx_q[e] + pyy_q[e]);
      cr_q[e]  <= {pc1_q[e][PROD_W-1], pc1_q[e]} - {pc2_q[e][PROD_W-1], pc2_q[e]};
      z2_q[e]  <= z1_q[e];

      // open the square root of L * 2^20; fold winding into the sign
      sq_q[0][e].rad  <= {1'b0, lsq_q[e], LEN_FRAC'(0)};
      sq_q[0][e].rem  <= '0;
      sq_q[0][e].root <= '0;
      sq_q[0][e].mag  <= cr_q[e][CROSS_W-1] ? CROSS_W'(-cr_q[e]) : CROSS_W'(cr_q[e]);
      sq_q[0][e].neg  <= cr_q[e][CROSS_W-1] ^ aneg_q;
      sq_q[0][e].zero <= z2_q[e];
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_q[k+1][e] <= sq_step(sq_q[k][e]);
      end

      // rounded quotient: (2*mag*1024 + len) / (2*len)
      pre_q[e].num  <= {sq_q[SQ_STEPS][e].mag, DIST_SH'(0)}
                       + NUM_W'(sq_q[SQ_STEPS][e].root);
      pre_q[e].den  <= {sq_q[SQ_STEPS][e].root, 1'b0};
      pre_q[e].neg  <= sq_q[SQ_STEPS][e].neg;
      pre_q[e].zero <= sq_q[SQ_STEPS][e].zero;

      // a quotient that would not fit the divider is clamped later
      dv_q[0][e].den  <= pre_q[e].den;
      dv_q[0][e].rem  <= pre_q[e].num[NUM_W-1 -: DEN_W];
      dv_q[0][e].lo   <= pre_q[e].num[QUO_W-1:0];
      dv_q[0][e].quo  <= '0;
      dv_q[0][e].ovf  <= pre_q[e].num >= {pre_q[e].den, QUO_W'(0)};
      dv_q[0][e].neg  <= pre_q[e].neg;
      dv_q[0][e].zero <= pre_q[e].zero;
      for (int k = 0; k < DV_STEPS; k++) begin
        dv_q[k+1][e] <= dv_step(dv_q[k][e]);
      end

      dval_q[e] <= dv_q[DV_STEPS][e].neg
                   ? -$signed({1'b0, dv_q[DV_STEPS][e].ovf ? {QUO_W{1'b1}}
                                                           : dv_q[DV_STEPS][e].quo})
                   :  $signed({1'b0, dv_q[DV_STEPS][e].ovf ? {QUO_W{1'b1}}
                                                           : dv_q[DV_STEPS][e].quo});
      dok_q[e]  <= !dv_q[DV_STEPS][e].zero;
    end

    // twice the signed area: e0 x (-e2)
    ar1_q  <= ey_q[0] * ex_q[2];
    ar2_q  <= ex_q[0] * ey_q[2];
    aneg_q <= ($signed({ar1_q[PROD_W-1], ar1_q}) - $signed({ar2_q[PROD_W-1], ar2_q})) < 0;

    best_q <= best_d;
  end

  // hold the result between strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_margin_q <= '0;
    end else if (vld_q[LATENCY-2]) begin
      if (best_q > OUT_MAX) begin
        edge_margin_q <= OUT_MAX[OUT_W-1:0];
      end else if (best_q < OUT_MIN) begin
        edge_margin_q <= OUT_MIN[OUT_W-1:0];
      end else begin
        edge_margin_q <= best_q[OUT_W-1:0];
      end
    end
  end

  assign done_o        = vld_q[LATENCY-1];
  assign edge_margin_o = edge_margin_q;

endmodule

>>> rtl/tem_checker.sv
module tem_checker import tem_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [OUT_W-1:0] edge_margin_o
);

  // every accepted word yields its strobe after the pipeline depth
  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("missing result strobe");

  // no strobe without a command
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a command");

  // the result holds between strobes
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o && !$past(done_o)) |-> $stable(edge_margin_o))
    else $error("result changed between strobes");

endmodule

bind triangle_edge_margin tem_checker u_tem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .edge_margin_o (edge_margin_o)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tem_pkg::*;

  // Register map of the anchor write channel: x then y for each anchor.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANCHOR0_X, REG_ANCHOR0_Y, REG_ANCHOR1_X, REG_ANCHOR1_Y,
    REG_ANCHOR2_X, REG_ANCHOR2_Y, REG_ANCHOR3_X, REG_ANCHOR3_Y,
    REG_UNMAPPED = CFG_IDX_W'(11)
  } anchor_reg_e;

  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [SKIP_W-1:0]         skipped_anchor_i = '0;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic                      done_o;
  logic signed [OUT_W-1:0]   edge_margin_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [COORD_W-1:0]        cfg_data_i = '0;

  // Our copy of the anchor registers, updated as each write is taken.
  logic signed [COORD_W-1:0] anchor_x [4];
  logic signed [COORD_W-1:0] anchor_y [4];

  logic signed [OUT_W-1:0] margin_queue [$];
  int unsigned words_taken = 0;
  int unsigned writes_taken = 0;
  int unsigned mismatches = 0;
  bit          failed = 1'b0;
  bit          idle_enable = 1'b1;

  triangle_edge_margin uut (
    .clk_i, .rst_ni, .start, .busy, .skipped_anchor_i, .point_x_i, .point_y_i,
    .done_o, .edge_margin_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Floor square root, bit by bit.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Smallest signed distance from the point to the triangle's edges.
  function automatic logic signed [OUT_W-1:0] min_edge_margin(
      logic [SKIP_W-1:0] skip, logic signed [COORD_W-1:0] px,
      logic signed [COORD_W-1:0] py);
    longint vx [3];
    longint vy [3];
    longint area2, best, ex, ey, cr, margin;
    longint unsigned lsq, len, mag, quo;
    int n, f;
    bit have, neg, flip;
    n = 0;
    best = 0;
    have = 0;
    for (int i = 0; i < 4 && n < 3; i++) begin
      if (i != skip) begin
        vx[n] = anchor_x[i];
        vy[n] = anchor_y[i];
        n++;
      end
    end
    area2 = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
    flip = (area2 < 0);
    for (int e = 0; e < 3; e++) begin
      f = (e + 1) % 3;
      ex = vx[f] - vx[e];
      ey = vy[f] - vy[e];
      if (ex != 0 || ey != 0) begin
        lsq = ex * ex + ey * ey;
        len = floor_root(lsq << LEN_FRAC);
        cr = ex * (longint'(py) - vy[e]) - ey * (longint'(px) - vx[e]);
        neg = (cr < 0);
        mag = neg ? -cr : cr;
        quo = (2 * mag * 1024 + len) / (2 * len);
        if (flip) neg = !neg;
        margin = neg ? -longint'(quo) : longint'(quo);
        if (!have || margin < best) begin
          best = margin;
          have = 1;
        end
      end
    end
    if (best > 2097151) best = 2097151;
    if (best < -2097152) best = -2097152;
    return OUT_W'(best);
  endfunction

  // Watch both input channels and the result strobe at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i < 8) begin
          if (cfg_index_i[0]) anchor_y[cfg_index_i[2:1]] = cfg_data_i;
          else anchor_x[cfg_index_i[2:1]] = cfg_data_i;
        end
        writes_taken++;
      end
      if (start && !busy) begin
        margin_queue.push_back(min_edge_margin(skipped_anchor_i, point_x_i, point_y_i));
        words_taken++;
      end
      if (done_o) begin
        if (margin_queue.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: edge_margin %0d", edge_margin_o);
        end else if (margin_queue[0] !== edge_margin_o) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("edge_margin mismatch: expected %0d, got %0d",
                     margin_queue[0], edge_margin_o);
          void'(margin_queue.pop_front());
        end else begin
          void'(margin_queue.pop_front());
        end
      end
    end
  end

  // Present one command word and hold it until it is taken.
  task automatic send_point(logic [SKIP_W-1:0] skip, int px, int py);
    int unsigned seen;
    seen = words_taken;
    start <= 1'b1;
    skipped_anchor_i <= skip;
    point_x_i <= COORD_W'(px);
    point_y_i <= COORD_W'(py);
    wait (words_taken != seen);
    // random idle between words
    if (idle_enable && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    int unsigned seen;
    seen = writes_taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= COORD_W'(value);
    wait (writes_taken != seen);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop start and hold until every expected word is back, plus pipeline slack.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (margin_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_anchor(int a, int x, int y);
    write_reg(CFG_IDX_W'(REG_ANCHOR0_X + 2 * a), x);
    write_reg(CFG_IDX_W'(REG_ANCHOR0_Y + 2 * a), y);
  endtask

  function automatic int rand_coord(int span);
    if (span >= COORD_MAX) return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Reset anchors all coincide: every edge degenerates, result is zero.
  task automatic test_reset_anchors;
    send_point(3'd0, 100, -100);
    send_point(3'd7, COORD_MAX, COORD_MIN);
    drain();
  endtask

  task automatic test_directed;
    set_anchor(0, 0, 0);
    set_anchor(1, 1600, 0);
    set_anchor(2, 0, 1600);
    set_anchor(3, 1600, 1600);
    // every skip value, including those above three
    for (int s = 0; s < 8; s++) send_point(3'(s), 400, 400);
    send_point(3'd3, COORD_MAX, COORD_MAX);
    send_point(3'd3, COORD_MIN, COORD_MIN);
    send_point(3'd0, COORD_MIN, COORD_MAX);
    send_point(3'd2, 0, 0);
    drain();
    // anchors at the coordinate extremes, clockwise winding
    set_anchor(0, COORD_MIN, COORD_MIN);
    set_anchor(1, COORD_MIN, COORD_MAX);
    set_anchor(2, COORD_MAX, COORD_MAX);
    set_anchor(3, COORD_MAX, COORD_MIN);
    for (int s = 0; s < 4; s++) send_point(3'(s), 0, 0);
    send_point(3'd5, COORD_MAX, COORD_MIN);
    send_point(3'd1, COORD_MIN, COORD_MAX);
    drain();
    // collinear anchors and a repeated anchor; unmapped index is ignored
    set_anchor(0, -300, -300);
    set_anchor(1, 0, 0);
    set_anchor(2, 300, 300);
    set_anchor(3, 0, 0);
    write_reg(REG_UNMAPPED, 12345);
    send_point(3'd3, 50, -70);
    send_point(3'd0, -20, 90);
    send_point(3'd2, 7, 7);
    drain();
  endtask

  // Random anchor sets, mostly compact so points land inside and around.
  task automatic test_random(int phases, int per_phase);
    int span;
    int ax, ay;
    for (int p = 0; p < phases; p++) begin
      span = ($urandom_range(3) == 0) ? COORD_MAX : int'($urandom_range(50, 5000));
      for (int a = 0; a < 4; a++) begin
        if ($urandom_range(9) == 0 && a > 0) set_anchor(a, ax, ay);
        else begin
          ax = rand_coord(span);
          ay = rand_coord(span);
          set_anchor(a, ax, ay);
        end
      end
      idle_enable = (p != 2);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) == 0)
          send_point(3'($urandom), rand_coord(COORD_MAX), rand_coord(COORD_MAX));
        else
          send_point(3'($urandom), rand_coord(span), rand_coord(span));
      end
      drain();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    for (int a = 0; a < 4; a++) begin
      anchor_x[a] = '0;
      anchor_y[a] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_anchors();
    test_directed();
    test_random(23, 80);
    if (!failed && margin_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
